FILE: rtl/bloom_filter_engine_core_assert.svh
// ----------------------------------------------------------------------------
// Bloom filter engine assertion macros
// Shared concurrent assertion forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_ENGINE_CORE_ASSERT_SVH
`define BLOOM_FILTER_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define BFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter engine package
// Sizes, codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bfe_pkg;

	localparam int MAX_BYTES   = 16;
	localparam int FILTER_BITS = MAX_BYTES * 8;
	localparam int BYTE_IDX_W  = $clog2(MAX_BYTES);
	localparam int SIZE_W      = $clog2(MAX_BYTES + 1);
	localparam int BIT_IDX_W   = $clog2(FILTER_BITS);
	localparam int HCNT_W      = 6;
	localparam int ACTION_W    = 3;
	localparam int KEY_W       = 64;
	localparam int BVAL_W      = 8;
	localparam int COUNT_W     = 8;
	localparam int BCNT_W      = 4;
	localparam int SUM_W       = $clog2(FILTER_BITS + 1);

	localparam int IN_BITS     = ACTION_W + KEY_W + BYTE_IDX_W + BVAL_W;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 1 + COUNT_W;
	localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 6;

	// Only state bits [30:0] feed the position bits [30:16].
	localparam int LCG_W       = 31;
	localparam int POS_W       = 15;
	localparam int POS_LSB     = 16;
	localparam logic [LCG_W-1:0] LCG_MUL = 31'd1103515245;
	localparam logic [LCG_W-1:0] LCG_ADD = 31'd12345;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
	localparam logic [HCNT_W-1:0] HCNT_RESET = HCNT_W'(3);

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_BYTES = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = CFG_IDX_W'(1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD   = 3'd0,
		ACT_TEST  = 3'd1,
		ACT_DEL   = 3'd2,
		ACT_INIT  = 3'd3,
		ACT_CLEAR = 3'd4,
		ACT_MERGE = 3'd5
	} action_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_HASH  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_APPLY = 6'b001000,
		ST_COUNT = 6'b010000,
		ST_SUM   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic apply;
		logic count;
		logic result;
	} cmd_t;

	typedef struct packed {
		logic hash_op;
		logic pipe_busy;
		logic out_full;
	} sts_t;

endpackage

FILE: rtl/bfe_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter engine controller
// Sequences load, hash steps, drain, apply, popcount and result hand-off.
// ----------------------------------------------------------------------------
module bfe_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic [bfe_pkg::HCNT_W-1:0] hash_count,
	input  bfe_pkg::sts_t             sts,
	output logic                      s_tready,
	output bfe_pkg::cmd_t             cmd
);
	import bfe_pkg::*;

	state_t             state_q;
	state_t             state_n;
	logic [HCNT_W-1:0]  cnt_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_n  = ST_HASH;
				end
			end
			ST_HASH: begin
				if (!sts.hash_op) begin
					state_n = ST_APPLY;
				end else if (cnt_q == hash_count) begin
					state_n = ST_DRAIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_n = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_n   = ST_COUNT;
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_n   = ST_SUM;
			end
			ST_SUM: begin
				if (!sts.out_full) begin
					cmd.result = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + HCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/bfe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter engine datapath
// LCG hash pipeline, position modulo, key mask, filter array, popcount, output.
// ----------------------------------------------------------------------------
module bfe_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bfe_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [bfe_pkg::SIZE_W-1:0]    size_bytes,
	input  logic                          m_tready,
	input  bfe_pkg::cmd_t                 cmd,
	output bfe_pkg::sts_t                 sts,
	output logic                          m_tvalid,
	output logic [bfe_pkg::OUT_DATA_W-1:0] m_tdata
);
	import bfe_pkg::*;

	localparam int KEY_LSB  = ACTION_W;
	localparam int IDX_LSB  = KEY_LSB + KEY_W;
	localparam int BVAL_LSB = IDX_LSB + BYTE_IDX_W;
	localparam int QHI_W    = (POS_W - 3) / 2;
	localparam int QLO_W    = (POS_W - 3) - QHI_W;

	logic [ACTION_W-1:0]         action_q;
	logic [BYTE_IDX_W-1:0]       idx_q;
	logic [BVAL_W-1:0]           bval_q;
	logic [SIZE_W-1:0]           m_q;
	logic [LCG_W-1:0]            lcg_q;
	logic [2*LCG_W-1:0]          lcg_prod;
	logic [LCG_W-1:0]            lcg_next;
	logic [POS_W-1:0]            pos_s1;
	logic                        v_s1;
	logic [BYTE_IDX_W-1:0]       rem_s2;
	logic [QLO_W-1:0]            qlo_s2;
	logic [2:0]                  bit_s2;
	logic                        v_s2;
	logic [BYTE_IDX_W-1:0]       rem_fin;
	logic [BIT_IDX_W-1:0]        bitpos;
	logic [FILTER_BITS-1:0]      mask_q;
	logic [MAX_BYTES-1:0][7:0]   filter_q;
	logic [MAX_BYTES-1:0][7:0]   filter_n;
	logic [MAX_BYTES-1:0][7:0]   mask_b;
	logic [MAX_BYTES-1:0][BCNT_W-1:0] bcnt_q;
	logic                        present_n;
	logic                        present_q;
	logic [SUM_W-1:0]            sum_n;
	logic [COUNT_W-1:0]          count_n;
	logic [SIZE_W-1:0]           m_sat;
	logic                        out_valid_q;
	logic                        out_present_q;
	logic [COUNT_W-1:0]          out_count_q;

	function automatic logic [BYTE_IDX_W-1:0] mod_steps(
		input logic [BYTE_IDX_W-1:0] rem_in,
		input logic [QLO_W-1:0]      bits,
		input logic [SIZE_W-1:0]     d
	);
		logic [BYTE_IDX_W:0] r;
		r = {1'b0, rem_in};
		for (int i = QLO_W - 1; i >= 0; i--) begin
			r = {r[BYTE_IDX_W-1:0], bits[i]};
			if (r >= (BYTE_IDX_W + 1)'(d)) begin
				r = r - (BYTE_IDX_W + 1)'(d);
			end
		end
		return r[BYTE_IDX_W-1:0];
	endfunction

	always_comb begin
		if (size_bytes == '0) begin
			m_sat = SIZE_W'(1);
		end else if (size_bytes > SIZE_W'(MAX_BYTES)) begin
			m_sat = SIZE_W'(MAX_BYTES);
		end else begin
			m_sat = size_bytes;
		end
	end

	assign lcg_prod = lcg_q * LCG_MUL;
	assign lcg_next = lcg_prod[LCG_W-1:0] + LCG_ADD;

	assign rem_fin = mod_steps(rem_s2, qlo_s2, m_q);
	assign bitpos  = {rem_fin, bit_s2};
	assign mask_b  = mask_q;

	always_comb begin
		for (int b = 0; b < MAX_BYTES; b++) begin
			filter_n[b] = filter_q[b];
			case (action_q)
				ACT_ADD:   filter_n[b] = filter_q[b] | mask_b[b];
				ACT_DEL:   filter_n[b] = filter_q[b] & ~mask_b[b];
				ACT_INIT: begin
					if (SIZE_W'(b) < m_q) begin
						filter_n[b] = mask_b[b];
					end
				end
				ACT_CLEAR: filter_n[b] = '0;
				ACT_MERGE: begin
					if ((SIZE_W'(b) < m_q) && (idx_q == BYTE_IDX_W'(b))) begin
						filter_n[b] = filter_q[b] | bval_q;
					end
				end
				default:   filter_n[b] = filter_q[b];
			endcase
		end
	end

	assign present_n = (action_q == ACT_TEST) && ((filter_q & mask_q) == mask_q);

	always_comb begin
		sum_n = '0;
		for (int b = 0; b < MAX_BYTES; b++) begin
			if (SIZE_W'(b) < m_q) begin
				sum_n = sum_n + SUM_W'(bcnt_q[b]);
			end
		end
	end

	assign count_n = (sum_n > SUM_W'(255)) ? COUNT_W'(255) : COUNT_W'(sum_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			filter_q    <= '0;
		end else begin
			v_s1 <= cmd.step;
			v_s2 <= v_s1;
			if (cmd.apply) begin
				filter_q <= filter_n;
			end
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= s_tdata[KEY_LSB-1:0];
			idx_q    <= s_tdata[BVAL_LSB-1:IDX_LSB];
			bval_q   <= s_tdata[BVAL_LSB+BVAL_W-1:BVAL_LSB];
			m_q      <= m_sat;
			lcg_q    <= s_tdata[KEY_LSB+LCG_W-1:KEY_LSB];
			mask_q   <= '0;
		end else begin
			if (cmd.step) begin
				lcg_q  <= lcg_next;
				pos_s1 <= lcg_next[POS_LSB+POS_W-1:POS_LSB];
			end
			if (v_s2) begin
				mask_q[bitpos] <= 1'b1;
			end
		end
		if (v_s1) begin
			rem_s2 <= mod_steps('0, pos_s1[POS_W-1:POS_W-QHI_W], m_q);
			qlo_s2 <= pos_s1[QLO_W+2:3];
			bit_s2 <= pos_s1[2:0];
		end
		if (cmd.apply) begin
			present_q <= present_n;
		end
		if (cmd.count) begin
			for (int b = 0; b < MAX_BYTES; b++) begin
				bcnt_q[b] <= BCNT_W'($countones(filter_q[b]));
			end
		end
		if (cmd.result) begin
			out_present_q <= present_q;
			out_count_q   <= count_n;
		end
	end

	assign sts.hash_op   = (action_q == ACT_ADD) || (action_q == ACT_TEST) ||
		(action_q == ACT_DEL) || (action_q == ACT_INIT);
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_full  = out_valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_count_q, out_present_q};

endmodule

FILE: rtl/bloom_filter_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter engine core
// Add, test, delete and init take hash_count LCG steps, one step per cycle,
// then go through a two-stage modulo and a pipeline drain before apply,
// popcount and result; clear, merge and unused actions skip to apply.
// One item in flight; the next is taken only after the result is registered.
// Reset clears the filter, sets size_bytes to 8 and hash_count to 3.
// ----------------------------------------------------------------------------
module bloom_filter_engine_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// action[2:0], key[66:3], byte_index[70:67], byte_value[78:71], zero pad
	input  logic [bfe_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// present[0], ones_count[8:1], zero pad
	output logic [bfe_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfe_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bfe_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [HCNT_W-1:0] hcnt_q;
	cmd_t              cmd;
	sts_t              sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			hcnt_q <= HCNT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SIZE_BYTES) begin
				size_q <= cfg_data[SIZE_W-1:0];
			end else if (cfg_index == REG_HASH_COUNT) begin
				hcnt_q <= cfg_data[HCNT_W-1:0];
			end
		end
	end

	bfe_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.hash_count (hcnt_q),
		.sts        (sts),
		.s_tready   (s_tready),
		.cmd        (cmd)
	);

	bfe_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.size_bytes (size_q),
		.m_tready   (m_tready),
		.cmd        (cmd),
		.sts        (sts),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata)
	);

endmodule

FILE: rtl/bfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter engine port checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`include "bloom_filter_engine_core_assert.svh"

module bfe_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [bfe_pkg::IN_DATA_W-1:0]     s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [bfe_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [bfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [bfe_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bfe_pkg::*;

	logic in_acc;
	logic cfg_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign cfg_acc = cfg_valid && cfg_ready && (cfg_index == cfg_index) && (cfg_data == cfg_data)
		&& (s_tdata == s_tdata);

	`BFE_ASSERT_NEXT(a_one_item_in_flight, clk, arst_n, in_acc, !s_tready, "input taken while busy")
	`BFE_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_acc || cfg_acc, !$rose(m_tvalid) || !in_acc, "result too early")
	`BFE_ASSERT_IMP(a_count_range, clk, arst_n, m_tvalid, (m_tdata[8:1] <= 8'd128) && (m_tdata[15:9] == 7'd0), "count out of range")
	`BFE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind bloom_filter_engine_core bfe_checker u_bfe_checker (.*);
